// ===== sv/ugbp_pkg.sv =====
// shared types, codes and defaults of the uniform grid broad phase
package ugbp_pkg;

  // default geometry and storage sizes
  localparam int MAX_COLS_DEF   = 16;
  localparam int MAX_ROWS_DEF   = 16;
  localparam int CELL_SLOTS_DEF = 8;
  localparam int ID_BITS_DEF    = 8;

  // field widths fixed by the interface
  localparam int COORD_W      = 16;
  localparam int ID_FIELD_W   = 8;
  localparam int EXCL_W       = 9;
  localparam int DIM_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int RESULT_LIMIT = 64;
  localparam int SEEN_TAG_W   = 8;

  // opcodes
  localparam logic [1:0] OP_CLEAR        = 2'd0;
  localparam logic [1:0] OP_INSERT       = 2'd1;
  localparam logic [1:0] OP_QUERY_ALL    = 2'd2;
  localparam logic [1:0] OP_QUERY_UNIQUE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 2'd3;

  // configuration reset values
  localparam logic [COORD_W-1:0] CELL_SIZE_RST = 16'd64;
  localparam logic [4:0]         GRID_DIM_RST  = 5'd16;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [ID_FIELD_W-1:0] entity_id;
    logic [COORD_W-1:0]    box_left;
    logic [COORD_W-1:0]    box_top;
    logic [COORD_W-1:0]    box_right;
    logic [COORD_W-1:0]    box_bottom;
    logic [EXCL_W-1:0]     exclude_id;
  } in_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] found_id;
    logic                  found_valid;
    logic                  cell_overflow;
    logic                  truncated;
    logic                  last;
  } out_t;

endpackage

// ===== sv/ugbp_div.sv =====
// restoring divider, one quotient bit per cycle, zero divisor treated as one
module ugbp_div #(
  parameter int W = ugbp_pkg::COORD_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;
  logic             done_r;
  logic [W:0]       trial;
  logic             ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(W);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= (divisor == '0) ? W'(1) : divisor;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (ge) begin
          rem_r <= W'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[W-1:0];
        end
        quo_r <= {quo_r[W-2:0], ge};
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/uniform_grid_broad_phase.sv =====
// uniform grid broad phase: top level with cell memories and walk sequencer
//
// The block keeps a grid of cells, each holding a short list of entity ids in
// insertion order. A clear transaction empties every cell, an insert adds the id
// to every covered cell (flagging a full cell), and a query returns the ids in
// the covered cells, row by row, skipping the querying id and the exclude id,
// with a unique variant that returns each id once, at most 64 results. One item
// is worked on at a time. The covered column and row range takes four divisions
// on one shared bit-serial divider. An insert then visits each covered cell in
// turn and then gives its result. A query visits each covered cell and each
// stored id in it, then gives the final result, waiting while the result side
// stalls. Fill counts and the seen map live in synchronous memories with a read
// and a write port; a clear sweeps max(cells, ids) entries, one a cycle, as does
// the pass that follows reset. Every 255th query the seen-map tag wraps and a
// pass of the same length wipes the seen map alone, leaving the stored ids in
// place. Configuration is written through its own port; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module uniform_grid_broad_phase #(
  parameter int MAX_COLS   = ugbp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = ugbp_pkg::MAX_ROWS_DEF,
  parameter int CELL_SLOTS = ugbp_pkg::CELL_SLOTS_DEF,
  parameter int ID_BITS    = ugbp_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ugbp_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ugbp_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ugbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ugbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COORD_W  = ugbp_pkg::COORD_W;
  localparam int DIM_W    = ugbp_pkg::DIM_W;
  localparam int QTAG_W   = ugbp_pkg::SEEN_TAG_W;
  localparam int NCELLS   = MAX_COLS * MAX_ROWS;
  localparam int NSLOTS   = NCELLS * CELL_SLOTS;
  localparam int ID_COUNT = 1 << ID_BITS;
  localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELL_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SLOT_AW  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int FILL_W   = $clog2(CELL_SLOTS + 1);
  localparam int SWEEP_N  = (NCELLS > ID_COUNT) ? NCELLS : ID_COUNT;
  localparam int SW_W     = $clog2(SWEEP_N);
  localparam int XW       = (ID_BITS > ugbp_pkg::EXCL_W) ? ID_BITS : ugbp_pkg::EXCL_W;
  localparam int N_W      = $clog2(ugbp_pkg::RESULT_LIMIT + 1);
  localparam logic [QTAG_W-1:0] QTAG_MAX = '1;

  // sequencer states
  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_FILL_RD  = 4'd3;
  localparam logic [3:0] S_FILL_CHK = 4'd4;
  localparam logic [3:0] S_SLOT_RD  = 4'd5;
  localparam logic [3:0] S_SLOT_CHK = 4'd6;
  localparam logic [3:0] S_SEEN_CHK = 4'd7;
  localparam logic [3:0] S_FOUND    = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  // configuration registers
  logic [COORD_W-1:0] cell_width_r;
  logic [COORD_W-1:0] cell_height_r;
  logic [4:0]         cells_across_r;
  logic [4:0]         cells_down_r;
  logic [DIM_W-1:0]   ncols;
  logic [DIM_W-1:0]   nrows;

  // sequencer and item
  logic [3:0]          state_r;
  ugbp_pkg::in_t       item_r;
  logic [ID_BITS-1:0]  me;
  logic                is_insert;
  logic                is_unique;

  // span divider
  logic [1:0]          div_sel_r;
  logic                div_go_r;
  logic                div_start;
  logic                div_done;
  logic [COORD_W-1:0]  div_quo;
  logic [COORD_W-1:0]  div_num;
  logic [COORD_W-1:0]  div_den;
  logic [DIM_W-1:0]    div_lim;
  logic [COORD_W-1:0]  quo_clamp;
  logic [IDX_W-1:0]    quo_idx;

  // walk position
  logic [IDX_W-1:0]    c0_r, c1_r, r0_r, r1_r, c_r, r_r;
  logic [FILL_W-1:0]   s_r;
  logic [FILL_W-1:0]   fill_cur_r;
  logic [CELL_W-1:0]   cell_addr;
  logic [SLOT_AW-1:0]  slot_base;
  logic                last_slot;
  logic                last_col;
  logic                last_row;

  // memories
  logic [FILL_W-1:0]   fill_mem [NCELLS];
  logic [ID_BITS-1:0]  slot_mem [NSLOTS];
  logic [QTAG_W-1:0]   seen_mem [ID_COUNT];
  logic [FILL_W-1:0]   fill_q;
  logic [ID_BITS-1:0]  slot_q;
  logic [QTAG_W-1:0]   seen_q;
  logic                fill_we;
  logic [CELL_W-1:0]   fill_wa;
  logic [FILL_W-1:0]   fill_wd;
  logic                slot_we;
  logic                seen_we;
  logic [ID_BITS-1:0]  seen_wa;
  logic [QTAG_W-1:0]   seen_wd;
  logic                cell_full;

  // query bookkeeping
  logic                ovf_r;
  logic                trunc_r;
  logic                pend_valid_r;
  logic [ID_BITS-1:0]  pend_id_r;
  logic [N_W-1:0]      n_r;
  logic [QTAG_W-1:0]   qnum_r;
  logic [SW_W-1:0]     sweep_r;
  logic                wipe_fill_r;
  logic                sweeping;
  logic                sweep_fill;
  logic                sweep_seen;
  logic                skip_id;
  logic                found_take;
  logic                ofree;

  // output register
  logic                out_valid_r;
  logic                out_load;
  ugbp_pkg::out_t      out_data_r;

  // effective grid size: zero acts as one, clamp at the build size
  always_comb begin
    if (cells_across_r == '0) begin
      ncols = DIM_W'(1);
    end else if (DIM_W'(cells_across_r) > DIM_W'(MAX_COLS)) begin
      ncols = DIM_W'(MAX_COLS);
    end else begin
      ncols = DIM_W'(cells_across_r);
    end
    if (cells_down_r == '0) begin
      nrows = DIM_W'(1);
    end else if (DIM_W'(cells_down_r) > DIM_W'(MAX_ROWS)) begin
      nrows = DIM_W'(MAX_ROWS);
    end else begin
      nrows = DIM_W'(cells_down_r);
    end
  end

  assign me        = ID_BITS'(item_r.entity_id);
  assign is_insert = item_r.opcode == ugbp_pkg::OP_INSERT;
  assign is_unique = item_r.opcode == ugbp_pkg::OP_QUERY_UNIQUE;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r   <= ugbp_pkg::CELL_SIZE_RST;
      cell_height_r  <= ugbp_pkg::CELL_SIZE_RST;
      cells_across_r <= ugbp_pkg::GRID_DIM_RST;
      cells_down_r   <= ugbp_pkg::GRID_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ugbp_pkg::REG_CELL_WIDTH:   cell_width_r   <= cfg_data;
        ugbp_pkg::REG_CELL_HEIGHT:  cell_height_r  <= cfg_data;
        ugbp_pkg::REG_CELLS_ACROSS: cells_across_r <= cfg_data[4:0];
        ugbp_pkg::REG_CELLS_DOWN:   cells_down_r   <= cfg_data[4:0];
      endcase
    end
  end

  // divider operand selection: left, top, right, bottom in turn
  always_comb begin
    unique case (div_sel_r)
      2'd0:    div_num = item_r.box_left;
      2'd1:    div_num = item_r.box_top;
      2'd2:    div_num = item_r.box_right;
      default: div_num = item_r.box_bottom;
    endcase
  end

  assign div_den   = div_sel_r[0] ? cell_height_r : cell_width_r;
  assign div_lim   = div_sel_r[0] ? nrows : ncols;
  assign div_start = (state_r == S_DIV) && div_go_r;
  // saturate at the last column or row in use
  assign quo_clamp = (div_quo >= COORD_W'(div_lim)) ? COORD_W'(div_lim - 1'b1) : div_quo;
  assign quo_idx   = IDX_W'(quo_clamp);

  ugbp_div #(
    .W (COORD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // cell and slot addressing
  assign cell_addr = CELL_W'(r_r) * CELL_W'(MAX_COLS) + CELL_W'(c_r);
  assign slot_base = SLOT_AW'(cell_addr) * SLOT_AW'(CELL_SLOTS);
  assign last_slot = ({1'b0, s_r} + 1'b1) >= {1'b0, fill_cur_r};
  assign last_col  = c_r >= c1_r;
  assign last_row  = r_r >= r1_r;

  assign cell_full = fill_q >= FILL_W'(CELL_SLOTS);
  assign skip_id   = (slot_q == me) || (XW'(slot_q) == XW'(item_r.exclude_id));
  assign ofree     = !out_valid_r || !out_stall;
  assign found_take = (state_r == S_FOUND) && (n_r != N_W'(ugbp_pkg::RESULT_LIMIT))
                      && (!pend_valid_r || ofree);

  // clearing pass covers the seen tags, and the fill counts after reset or a clear
  assign sweeping   = state_r == S_SWEEP;
  assign sweep_fill = sweeping && wipe_fill_r &&
                      ({1'b0, sweep_r} < (SW_W + 1)'(NCELLS));
  assign sweep_seen = sweeping && ({1'b0, sweep_r} < (SW_W + 1)'(ID_COUNT));

  assign slot_we = (state_r == S_FILL_CHK) && is_insert && !cell_full;
  assign fill_we = sweep_fill || slot_we;
  assign fill_wa = sweeping ? CELL_W'(sweep_r) : cell_addr;
  assign fill_wd = sweeping ? '0 : FILL_W'(fill_q + 1'b1);
  assign seen_we = sweep_seen || found_take;
  assign seen_wa = sweeping ? ID_BITS'(sweep_r) : slot_q;
  assign seen_wd = sweeping ? '0 : qnum_r;

  // fill count memory
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_q <= fill_mem[cell_addr];
  end

  // slot list memory, entries above the fill count are never read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_base + SLOT_AW'(fill_q)] <= me;
    end
    slot_q <= slot_mem[slot_base + SLOT_AW'(s_r)];
  end

  // seen map as query tags: an id is seen when its tag equals the current query
  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_q <= seen_mem[slot_q];
  end

  // a result is loaded when a held id is pushed out or the item finishes
  assign out_load = (found_take && pend_valid_r) || ((state_r == S_FINISH) && ofree);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      wipe_fill_r  <= 1'b1;
      qnum_r       <= QTAG_W'(1);
      div_go_r     <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_SWEEP: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == SW_W'(SWEEP_N - 1)) begin
            qnum_r  <= QTAG_W'(1);
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            if (in_data.opcode == ugbp_pkg::OP_CLEAR) begin
              sweep_r     <= '0;
              wipe_fill_r <= 1'b1;
              state_r     <= S_SWEEP;
            end else begin
              div_sel_r    <= 2'd0;
              div_go_r     <= 1'b1;
              ovf_r        <= 1'b0;
              trunc_r      <= 1'b0;
              pend_valid_r <= 1'b0;
              n_r          <= '0;
              state_r      <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_go_r) begin
            div_go_r <= 1'b0;
          end else if (div_done) begin
            unique case (div_sel_r)
              2'd0:    c0_r <= quo_idx;
              2'd1:    r0_r <= quo_idx;
              // reversed box collapses onto the left or top edge
              2'd2:    c1_r <= (quo_idx < c0_r) ? c0_r : quo_idx;
              default: r1_r <= (quo_idx < r0_r) ? r0_r : quo_idx;
            endcase
            if (div_sel_r == 2'd3) begin
              c_r     <= c0_r;
              r_r     <= r0_r;
              state_r <= S_FILL_RD;
            end else begin
              div_sel_r <= div_sel_r + 1'b1;
              div_go_r  <= 1'b1;
            end
          end
        end

        S_FILL_RD: begin
          state_r <= S_FILL_CHK;
        end

        S_FILL_CHK: begin
          if (is_insert) begin
            if (cell_full) begin
              ovf_r <= 1'b1;
            end
            state_r <= S_NEXT;
          end else begin
            fill_cur_r <= fill_q;
            s_r        <= '0;
            state_r    <= (fill_q == '0) ? S_NEXT : S_SLOT_RD;
          end
        end

        S_SLOT_RD: begin
          state_r <= S_SLOT_CHK;
        end

        S_SLOT_CHK: begin
          priority if (skip_id) begin
            if (last_slot) begin
              state_r <= S_NEXT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_SLOT_RD;
            end
          end else if (is_unique) begin
            state_r <= S_SEEN_CHK;
          end else begin
            state_r <= S_FOUND;
          end
        end

        S_SEEN_CHK: begin
          if (seen_q == qnum_r) begin
            if (last_slot) begin
              state_r <= S_NEXT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_SLOT_RD;
            end
          end else begin
            state_r <= S_FOUND;
          end
        end

        S_FOUND: begin
          if (n_r == N_W'(ugbp_pkg::RESULT_LIMIT)) begin
            // one more id than the limit allows: stop the walk
            trunc_r <= 1'b1;
            state_r <= S_FINISH;
          end else if (found_take) begin
            // the held result goes out once a newer one shows it is not the last
            if (pend_valid_r) begin
              out_data_r.found_id        <= ugbp_pkg::ID_FIELD_W'(pend_id_r);
              out_data_r.found_valid     <= 1'b1;
              out_data_r.cell_overflow   <= 1'b0;
              out_data_r.truncated       <= 1'b0;
              out_data_r.last            <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_id_r    <= slot_q;
            n_r          <= n_r + 1'b1;
            if (last_slot) begin
              state_r <= S_NEXT;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_SLOT_RD;
            end
          end
        end

        S_NEXT: begin
          priority if (!last_col) begin
            c_r     <= c_r + 1'b1;
            state_r <= S_FILL_RD;
          end else if (!last_row) begin
            c_r     <= c0_r;
            r_r     <= r_r + 1'b1;
            state_r <= S_FILL_RD;
          end else begin
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (ofree) begin
            out_data_r.last      <= 1'b1;
            out_data_r.truncated <= trunc_r && !is_insert;
            if (is_insert) begin
              out_data_r.found_id      <= '0;
              out_data_r.found_valid   <= 1'b0;
              out_data_r.cell_overflow <= ovf_r;
              state_r                  <= S_IDLE;
            end else begin
              out_data_r.found_id      <= pend_valid_r ?
                                          ugbp_pkg::ID_FIELD_W'(pend_id_r) : '0;
              out_data_r.found_valid   <= pend_valid_r;
              out_data_r.cell_overflow <= 1'b0;
              pend_valid_r             <= 1'b0;
              qnum_r                   <= qnum_r + 1'b1;
              // tag space used up: wipe the seen map before the next query
              if (qnum_r == QTAG_MAX) begin
                sweep_r     <= '0;
                wipe_fill_r <= 1'b0;
                state_r     <= S_SWEEP;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ugbp_chk.sv =====
// port-level checks of the uniform grid broad phase and their binding
module ugbp_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ugbp_pkg::out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted item keeps the input side closed the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // a result with no id always closes its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found_valid |-> out_data.last)
    else $error("empty result not marked last");

  // overflow only on the single insert result
  a_ovf_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cell_overflow |-> out_data.last && !out_data.found_valid)
    else $error("overflow flag on a query result");

  // truncation only on a final found id
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |-> out_data.last && out_data.found_valid)
    else $error("truncated flag misplaced");

endmodule

bind uniform_grid_broad_phase ugbp_chk u_ugbp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
